// File: rtl/core/assert_macros.svh
// Assertion macros shared by the route table RTL.
// Depends on nothing; bodies compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/core/bfsrt_pkg.sv
// Package for the route table: status and operation codes, sequencer states.
// Depends on nothing.
package bfsrt_pkg;
	localparam int NODE_COUNT_DEF = 64;
	localparam int ID_W = 6;
	localparam logic [1:0] FN_ADD_NODE = 2'd0;
	localparam logic [1:0] FN_ADD_LINK = 2'd1;
	localparam logic [1:0] FN_ROUTE    = 2'd2;
	localparam logic [1:0] FN_UNUSED   = 2'd3;
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_MISSING = 3'd1;
	localparam logic [2:0] ST_EXISTS  = 3'd2;
	localparam logic [2:0] ST_LINK    = 3'd3;
	localparam logic [2:0] ST_NOROUTE = 3'd4;
	typedef enum logic [4:0] {
		S_IDLE, S_CHK, S_SCAN_RD, S_SCAN, S_LINK_WA, S_LINK_WB,
		S_VCLR, S_DEQ, S_DEQ_W, S_NB_RD, S_NB, S_BACK_RD, S_BACK,
		S_EMIT_RD, S_EMIT, S_RESP, S_DIRECT
	} state_t;
endpackage

// File: rtl/core/bfs_route_table.sv
// Route table over an undirected graph: add node, add link, find route (BFS).
// Uses bfsrt_pkg and assert_macros.svh.
// One item at a time; the input is ready only while the sequencer is idle. Add
// node, and any item that fails its presence check, goes from the check state
// to the response state. Add link and find route first scan the source's
// neighbor list, a read state and a compare state for each entry; add link
// then writes both lists in two write states and responds. A search passes a
// dequeue and a wait state for each dequeued node and a read and a check state
// for each neighbor entry, then walks back and emits the route through a read
// and a step state for each route node; the largest graph holds 4160 list
// entries. The visited marks are flip-flops cleared at search start, with only
// the source marked; presence flags are flip-flops cleared by reset, and the
// per-node neighbor counts sit in a small memory zeroed on add node. Results
// wait in a one-entry output register; emitting states stall while it is full.
`include "assert_macros.svh"
module bfs_route_table #(
	parameter int NODE_COUNT = bfsrt_pkg::NODE_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] func,
	input  logic [5:0] node_a,
	input  logic [5:0] node_b,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] status,
	output logic [5:0] route_node,
	output logic last
);
	import bfsrt_pkg::*;
	localparam int CAP = NODE_COUNT + 1;
	localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CW = $clog2(CAP + 1);
	localparam int DEPTH = NODE_COUNT * CAP;
	localparam int AW = $clog2(DEPTH);
	localparam int QW = $clog2(NODE_COUNT + 1);

	state_t state_q, state_d;
	logic [1:0] fn_q;
	logic [5:0] a_q, b_q;
	logic [NODE_COUNT-1:0] present_q, visited_q;
	logic [CW-1:0] cnt_a_q, cnt_b_q;
	logic [CW-1:0] idx_q;
	logic [NW-1:0] cur_q, k_q;
	logic [QW-1:0] head_q, tail_q, len_q, emit_q;
	logic [5:0] list_mem [DEPTH];
	logic [CW-1:0] cnt_mem [NODE_COUNT];
	logic [NW-1:0] prev_mem [NODE_COUNT];
	logic [NW-1:0] queue_mem [NODE_COUNT];
	logic [NW-1:0] path_mem [NODE_COUNT];
	logic [5:0] list_rd;
	logic [CW-1:0] cnt_rd;
	logic [NW-1:0] prev_rd, queue_rd, path_rd;
	logic ob_valid_q;
	logic [2:0] ob_st_q;
	logic [5:0] ob_node_q;
	logic ob_last_q;
	logic [2:0] st_hold_q;

	// decoded request
	logic a_ok, b_ok;
	logic [NW-1:0] a_i, b_i;
	assign a_i = NW'(a_q);
	assign b_i = NW'(b_q);
	assign a_ok = (32'(a_q) < NODE_COUNT) && present_q[a_i];
	assign b_ok = (32'(b_q) < NODE_COUNT) && present_q[b_i];

	// memory controls
	logic list_we;
	logic [AW-1:0] list_wa, list_ra;
	logic [5:0] list_wd;
	logic cnt_we;
	logic [NW-1:0] cnt_wa, cnt_ra;
	logic [CW-1:0] cnt_wd;
	logic q_we, p_we, pa_we;
	logic [NW-1:0] q_wa, q_wd, p_wa, p_wd, pa_wa, pa_wd, q_ra, p_ra, pa_ra;

	function automatic logic [AW-1:0] addr(input logic [NW-1:0] n, input logic [CW-1:0] i);
		return AW'(n) * AW'(CAP) + AW'(i);
	endfunction

	always_ff @(posedge clk) begin
		if (list_we) list_mem[list_wa] <= list_wd;
		list_rd <= list_mem[list_ra];
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		cnt_rd <= cnt_mem[cnt_ra];
		if (q_we) queue_mem[q_wa] <= q_wd;
		queue_rd <= queue_mem[q_ra];
		if (p_we) prev_mem[p_wa] <= p_wd;
		prev_rd <= prev_mem[p_ra];
		if (pa_we) path_mem[pa_wa] <= pa_wd;
		path_rd <= path_mem[pa_ra];
	end

	logic nb_ok;
	logic [NW-1:0] nb_i;
	assign nb_i = NW'(list_rd);
	assign nb_ok = (32'(list_rd) < NODE_COUNT) && !visited_q[nb_i]
		&& (32'(tail_q) < NODE_COUNT);

	logic ob_free;
	assign ob_free = !ob_valid_q || out_ready;
	logic ob_load;
	logic [2:0] ob_st_d;
	logic [5:0] ob_node_d;
	logic ob_last_d;

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		in_ready = (state_q == S_IDLE);
		list_we = 1'b0; list_wa = '0; list_wd = '0;
		list_ra = addr(a_i, idx_q);
		cnt_we = 1'b0; cnt_wa = a_i; cnt_wd = '0;
		cnt_ra = b_i;
		q_we = 1'b0; q_wa = tail_q[NW-1:0]; q_wd = '0;
		q_ra = head_q[NW-1:0];
		p_we = 1'b0; p_wa = nb_i; p_wd = cur_q;
		p_ra = k_q;
		pa_we = 1'b0; pa_wa = len_q[NW-1:0]; pa_wd = k_q;
		pa_ra = NW'(len_q - QW'(1) - emit_q);
		ob_load = 1'b0; ob_st_d = ST_OK; ob_node_d = '0; ob_last_d = 1'b1;
		case (state_q)
			S_IDLE: begin
				cnt_ra = NW'(node_a);
				if (in_valid && func != FN_UNUSED) state_d = S_CHK;
			end
			S_CHK: begin
				if (fn_q == FN_ADD_NODE) begin
					ob_st_d = (32'(a_q) >= NODE_COUNT) ? ST_MISSING
						: (present_q[a_i] ? ST_EXISTS : ST_OK);
					cnt_we = (32'(a_q) < NODE_COUNT) && !present_q[a_i];
					state_d = S_RESP;
				end else if (!a_ok || !b_ok) begin
					ob_st_d = ST_MISSING;
					state_d = S_RESP;
				end else if (cnt_rd == '0) begin
					state_d = (fn_q == FN_ROUTE) ? S_VCLR : S_LINK_WA;
				end else state_d = S_SCAN_RD;
			end
			S_SCAN_RD: state_d = S_SCAN;
			S_SCAN: begin
				if (list_rd == b_q) begin
					ob_st_d = ST_LINK;
					state_d = (fn_q == FN_ROUTE) ? S_DIRECT : S_RESP;
				end else if (idx_q + CW'(1) == cnt_a_q) begin
					state_d = (fn_q == FN_ROUTE) ? S_VCLR : S_LINK_WA;
				end else state_d = S_SCAN_RD;
			end
			// cnt_rd holds the count of node b here
			S_LINK_WA: begin
				if (32'(cnt_a_q) >= CAP || 32'(cnt_rd) >= CAP
					|| (a_q == b_q && 32'(cnt_a_q) + 1 >= CAP)) begin
					ob_st_d = ST_LINK;
					state_d = S_RESP;
				end else begin
					list_we = 1'b1; list_wa = addr(a_i, cnt_a_q); list_wd = b_q;
					cnt_we = 1'b1; cnt_wa = a_i; cnt_wd = cnt_a_q + CW'(1);
					state_d = S_LINK_WB;
				end
			end
			S_LINK_WB: begin
				list_we = 1'b1; list_wa = addr(b_i, cnt_b_q); list_wd = a_q;
				cnt_we = 1'b1; cnt_wa = b_i; cnt_wd = cnt_b_q + CW'(1);
				ob_st_d = ST_OK;
				state_d = S_RESP;
			end
			S_VCLR: begin
				q_we = 1'b1; q_wa = '0; q_wd = a_i;
				state_d = S_DEQ;
			end
			S_DEQ: state_d = (head_q < tail_q) ? S_DEQ_W : S_RESP;
			S_DEQ_W: begin
				cnt_ra = queue_rd;
				if (queue_rd == b_i) state_d = S_BACK_RD;
				else state_d = S_NB_RD;
			end
			// cnt_rd holds the count of the current node
			S_NB_RD: begin
				cnt_ra = cur_q;
				list_ra = addr(cur_q, idx_q);
				state_d = (idx_q == cnt_rd) ? S_DEQ : S_NB;
			end
			S_NB: begin
				cnt_ra = cur_q;
				if (nb_ok) begin
					q_we = 1'b1; q_wd = nb_i;
					p_we = 1'b1;
				end
				state_d = S_NB_RD;
			end
			S_BACK_RD: begin
				pa_we = 1'b1;
				if (k_q == a_i || 32'(len_q) >= NODE_COUNT - 1) begin
					pa_wd = a_i;
					state_d = S_EMIT_RD;
				end else state_d = S_BACK;
			end
			S_BACK: state_d = S_BACK_RD;
			S_EMIT_RD: state_d = S_EMIT;
			S_EMIT: if (ob_free) begin
				ob_load = 1'b1; ob_node_d = 6'(path_rd);
				ob_last_d = (emit_q + QW'(1) == len_q);
				state_d = ob_last_d ? S_IDLE : S_EMIT_RD;
			end
			S_DIRECT: if (ob_free) begin
				ob_load = 1'b1; ob_node_d = a_q; ob_last_d = 1'b0;
				state_d = S_RESP;
			end
			S_RESP: if (ob_free) begin
				ob_load = 1'b1; ob_st_d = st_hold_q;
				ob_node_d = (fn_q == FN_ROUTE && st_hold_q == ST_OK) ? b_q : 6'd0;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// status held for the response state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_hold_q <= ST_OK;
		else if (state_q == S_CHK || state_q == S_SCAN || state_q == S_LINK_WA
			|| state_q == S_LINK_WB) st_hold_q <= ob_st_d;
		else if (state_q == S_DEQ && state_d == S_RESP) st_hold_q <= ST_NOROUTE;
		else if (state_q == S_DIRECT && ob_load) st_hold_q <= ST_OK;
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			present_q <= '0;
			visited_q <= '0;
			idx_q <= '0; head_q <= '0; tail_q <= '0; len_q <= '0; emit_q <= '0;
			cur_q <= '0; k_q <= '0;
			fn_q <= '0; a_q <= '0; b_q <= '0;
			cnt_a_q <= '0; cnt_b_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					fn_q <= func; a_q <= node_a; b_q <= node_b; idx_q <= '0;
				end
				S_CHK: begin
					cnt_a_q <= cnt_rd;
					if (fn_q == FN_ADD_NODE && 32'(a_q) < NODE_COUNT
						&& !present_q[a_i]) present_q[a_i] <= 1'b1;
				end
				S_SCAN: idx_q <= idx_q + CW'(1);
				S_LINK_WA: cnt_b_q <= (a_q == b_q) ? cnt_a_q + CW'(1) : cnt_rd;
				S_VCLR: begin
					visited_q <= NODE_COUNT'(1) << a_i;
					head_q <= '0; tail_q <= QW'(1);
				end
				S_DEQ: if (head_q < tail_q) head_q <= head_q + QW'(1);
				S_DEQ_W: begin
					cur_q <= queue_rd; idx_q <= '0;
					k_q <= b_i; len_q <= '0;
				end
				S_NB: begin
					if (nb_ok) begin
						visited_q[nb_i] <= 1'b1;
						tail_q <= tail_q + QW'(1);
					end
					idx_q <= idx_q + CW'(1);
				end
				S_BACK_RD: begin
					len_q <= len_q + QW'(1);
					emit_q <= '0;
				end
				S_BACK: k_q <= prev_rd;
				S_EMIT: if (ob_load) emit_q <= emit_q + QW'(1);
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_valid_q <= 1'b0;
			ob_st_q <= ST_OK; ob_node_q <= '0; ob_last_q <= 1'b0;
		end else begin
			if (ob_load) begin
				ob_valid_q <= 1'b1;
				ob_st_q <= ob_st_d; ob_node_q <= ob_node_d; ob_last_q <= ob_last_d;
			end else if (out_ready) ob_valid_q <= 1'b0;
		end
	end

	assign out_valid = ob_valid_q;
	assign status = ob_st_q;
	assign route_node = ob_node_q;
	assign last = ob_last_q;

	`ASSERT_IMPL(a_load_free, clk, arst_n, ob_load |-> (!ob_valid_q || out_ready), "out overwrite")
	`ASSERT_IMPL(a_idle_ready, clk, arst_n, (in_valid && in_ready) |=> (state_q != S_IDLE || $past(func) == FN_UNUSED), "accept lost")
	`ASSERT_NEVER(a_queue_over, clk, arst_n, 32'(tail_q) > NODE_COUNT, "queue overflow")
	`ASSERT_IMPL(a_src_vis, clk, arst_n, (state_q == S_NB) |-> visited_q[a_i], "source unmarked")
endmodule

// File: bench/bfs_route_table_test.sv
`timescale 1ns / 1ps
// Self-checking bench for bfs_route_table: add node, add link, find route items.
// Depends on bfsrt_pkg and the bfs_route_table RTL.
module bfs_route_table_test;
	import bfsrt_pkg::*;

	localparam int NODES = 64;
	localparam int CAP = NODES + 1;
	localparam int STALL_LIMIT = 200000;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] route_node;
		logic       last;
	} hop_t;

	// Graph mirror plus the queue of results still owed by the block
	class route_scoreboard;
		bit present[NODES];
		int nb_count[NODES];
		logic [5:0] nb_list[NODES][CAP];
		hop_t owed[$];
		int errors;

		function void push(logic [2:0] st, int nd, bit lst);
			hop_t h;
			h.status = st;
			h.route_node = 6'(nd);
			h.last = lst;
			owed.insert(owed.size(), h);
		endfunction

		function bit linked(int a, int b);
			for (int i = 0; i < nb_count[a]; i++)
				if (nb_list[a][i] == b) return 1;
			return 0;
		endfunction

		// Presence and direct-link checks, then breadth-first search in stored neighbor order, then path emission
		function void route(int src, int dst);
			bit seen[NODES];
			int prev[NODES];
			int fifo[NODES];
			int path[NODES];
			int head, tail, len, k, cur, nb;
			bit found;
			head = 0; tail = 0; len = 0; found = 0;
			if (!present[src] || !present[dst]) begin
				push(ST_MISSING, 0, 1);
				return;
			end
			if (linked(src, dst)) begin
				push(ST_OK, src, 0);
				push(ST_OK, dst, 1);
				return;
			end
			foreach (seen[i]) seen[i] = 0;
			fifo[tail++] = src;
			seen[src] = 1;
			while (head < tail) begin
				cur = fifo[head++];
				if (cur == dst) begin
					found = 1;
					break;
				end
				for (int i = 0; i < nb_count[cur]; i++) begin
					nb = nb_list[cur][i];
					if (!seen[nb] && tail < NODES) begin
						seen[nb] = 1;
						prev[nb] = cur;
						fifo[tail++] = nb;
					end
				end
			end
			if (!found) begin
				push(ST_NOROUTE, 0, 1);
				return;
			end
			k = dst;
			while (k != src && len < NODES - 1) begin
				path[len++] = k;
				k = prev[k];
			end
			path[len++] = src;
			for (int i = 0; i < len; i++)
				push(ST_OK, path[len - 1 - i], i + 1 == len);
		endfunction

		function void note_input(logic [1:0] f, logic [5:0] a, logic [5:0] b);
			case (f)
				FN_ADD_NODE: begin
					if (present[a]) push(ST_EXISTS, 0, 1);
					else begin
						present[a] = 1;
						nb_count[a] = 0;
						push(ST_OK, 0, 1);
					end
				end
				FN_ADD_LINK: begin
					if (!present[a] || !present[b]) push(ST_MISSING, 0, 1);
					else if (linked(a, b)) push(ST_LINK, 0, 1);
					else if (nb_count[a] >= CAP || nb_count[b] >= CAP ||
							(a == b && nb_count[a] + 1 >= CAP))
						push(ST_LINK, 0, 1);
					else begin
						nb_list[a][nb_count[a]++] = b;
						nb_list[b][nb_count[b]++] = a;
						push(ST_OK, 0, 1);
					end
				end
				FN_ROUTE: route(a, b);
				default: ;
			endcase
		endfunction

		function void check_result(logic [2:0] st, logic [5:0] nd, logic lst);
			hop_t e;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result status=%0d node=%0d last=%0d",
					$realtime, st, nd, lst);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (st !== e.status || nd !== e.route_node || lst !== e.last) begin
				$display("%0t: mismatch expected status=%0d node=%0d last=%0d, got %0d %0d %0d",
					$realtime, e.status, e.route_node, e.last, st, nd, lst);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] func;
	logic [5:0] node_a;
	logic [5:0] node_b;
	logic out_valid;
	logic out_ready;
	logic [2:0] status;
	logic [5:0] route_node;
	logic last;

	route_scoreboard sb;
	bit hold_req;
	bit stim_done;
	int idle_cycles;

	bfs_route_table DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .node_a(node_a), .node_b(node_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .route_node(route_node), .last(last)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic int gap_len();
		if ($urandom_range(9) == 0) return $urandom_range(40, 5);
		return $urandom_range(2);
	endfunction

	// One input transfer; handshake sampled at the falling edge before acceptance
	task automatic send_item(logic [1:0] f, logic [5:0] a, logic [5:0] b);
		bit taken;
		in_valid <= 1;
		func <= f;
		node_a <= a;
		node_b <= b;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end
		sb.note_input(f, a, b);
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [5:0] pick_id();
		if ($urandom_range(7) == 0) return 6'($urandom_range(63));
		return 6'($urandom_range(15));
	endfunction

	// Stimulus: directed corners, then mostly well-formed random traffic
	initial begin
		int r;
		logic [1:0] f;
		sb = new();
		in_valid = 0;
		func = 0;
		node_a = 0;
		node_b = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_item(FN_ADD_NODE, 0, 0);
		send_item(FN_ADD_NODE, 0, 63);
		send_item(FN_ADD_NODE, 63, 0);
		send_item(FN_ADD_NODE, 1, 0);
		send_item(FN_ADD_NODE, 2, 0);
		send_item(FN_ADD_NODE, 3, 0);
		send_item(FN_ROUTE, 0, 5);
		send_item(FN_ADD_LINK, 0, 9);
		send_item(FN_ADD_LINK, 0, 1);
		send_item(FN_ADD_LINK, 0, 1);
		send_item(FN_ADD_LINK, 1, 0);
		send_item(FN_ADD_LINK, 1, 2);
		send_item(FN_ADD_LINK, 2, 3);
		send_item(FN_ADD_LINK, 3, 3);
		send_item(FN_ROUTE, 0, 3);
		send_item(FN_ROUTE, 0, 1);
		send_item(FN_ROUTE, 3, 3);
		send_item(FN_ROUTE, 0, 0);
		send_item(FN_ROUTE, 0, 63);
		send_item(FN_UNUSED, 42, 21);
		send_item(FN_ADD_LINK, 63, 63);
		send_item(FN_ROUTE, 63, 63);
		send_item(FN_ROUTE, 3, 0);
		idle_gap(1);

		// sender pause: let the block drain completely
		while (sb.owed.size() != 0) @(posedge clk);
		hold_req = 1;

		for (int n = 0; n < 108; n++) begin
			r = $urandom_range(99);
			if (r < 15) f = FN_ADD_NODE;
			else if (r < 60) f = FN_ADD_LINK;
			else if (r < 92) f = FN_ROUTE;
			else f = FN_UNUSED;
			if (r >= 96) send_item(f, 6'($urandom_range(63)), 6'($urandom_range(63)));
			else send_item(f, pick_id(), pick_id());
			if (n > 20 || !hold_req) idle_gap(gap_len());
		end
		in_valid <= 0;
		stim_done = 1;
	end

	// Receiver: random backpressure plus one long hold while the sender keeps going
	initial begin
		int n;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 0;
				repeat (600) @(posedge clk);
			end
			out_ready <= 1;
			n = $urandom_range(3) == 0 ? $urandom_range(20, 1) : $urandom_range(8, 1);
			repeat (n) @(posedge clk);
			if ($urandom_range(2) == 0) begin
				out_ready <= 0;
				repeat (gap_len() + 1) @(posedge clk);
			end
		end
	end

	// Result check and stall watchdog, sampled mid-cycle
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(status, route_node, last);
			if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("bfs_route_table_test failed");
				$finish;
			end
		end
	end

	// End of run: wait for all owed results, then a quiet stretch
	initial begin
		wait (stim_done);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("bfs_route_table_test passed");
		else
			$display("bfs_route_table_test failed");
		$finish;
	end
endmodule
